FILE: design/sss_pkg.sv
// Shared types for the sample set statistics block.
// No dependencies; imported by the cell and top-level files.
package sss_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  // Broadcast control for the sorting cell chain.
  typedef struct packed {
    logic load;   // insert the broadcast sample in order
    logic shift;  // move every entry one place toward cell zero
  } cell_ctl_t;

endpackage

FILE: design/sss_cell.sv
// One cell of the insertion-sort chain: holds one sorted sample.
// Depends on sss_pkg for the chain control struct.
module sss_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  sss_pkg::cell_ctl_t            ctl,
  input  logic                          occupied,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [SAMPLE_BITS-1:0] left_data,
  input  logic                          left_gt,
  input  logic signed [SAMPLE_BITS-1:0] right_data,
  output logic signed [SAMPLE_BITS-1:0] data,
  output logic                          gt
);
  import sss_pkg::*;

  logic signed [SAMPLE_BITS-1:0] data_next;

  // Strict compare keeps equal samples ahead of the new one.
  assign gt = occupied && (data > sample_in);

  always_comb begin
    data_next = data;
    if (ctl.load) begin
      if (left_gt) begin
        data_next = left_data;
      end else if (gt || !occupied) begin
        data_next = sample_in;
      end
    end else if (ctl.shift) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: design/sss_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend,
// unsigned divisor, quotient truncated toward zero. No package use.
module sss_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);
  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic              run;
  logic [ITER_W-1:0] iter;
  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  diff;

  assign shifted  = {rem, num[NUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, den};
  assign quotient = neg ? -$signed(num) : $signed(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (start) begin
      run  <= 1'b1;
      done <= 1'b0;
      iter <= ITER_W'(NUM_W);
    end else if (run) begin
      iter <= iter - 1'b1;
      if (iter == ITER_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[NUM_W-1] ? -dividend : dividend;
      neg <= dividend[NUM_W-1];
      rem <= '0;
      den <= divisor;
    end else if (run) begin
      if (!diff[DEN_W+1]) begin
        rem <= diff[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: design/sample_set_statistics.sv
// Top level of the sample set statistics block: sorting cell chain,
// running min/max/sum and the mean divider. Depends on sss_pkg,
// sss_cell and sss_div.
//
// Usage: present one signed sample with start high; it is taken at a clock
// edge where busy is low, so a set streams in at one sample per cycle. A
// sample with last high closes the set. The block then raises busy while it
// drains the sorted chain toward cell zero to pick out the middle entries
// and runs the mean through a bit-serial divider, one quotient bit per
// cycle. Busy lasts until both the drain and the divider, which works on a
// sum of SUM_W = SAMPLE_BITS + clog2(MAX_SAMPLES) bits, are through. The
// result then appears for exactly one cycle with done high; there is no
// way to hold it off, so capture it on that cycle. Samples that arrive
// while MAX_SAMPLES are kept are dropped and reported through overflow.
// The mean truncates toward zero; the even-count median is the floor of
// the mean of the two middle values.
module sample_set_statistics #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic signed [SAMPLE_BITS-1:0]                  sample,
  input  logic                                           last,
  output logic                                           busy,
  output logic                                           done,
  output logic signed [SAMPLE_BITS-1:0]                  min_value,
  output logic signed [SAMPLE_BITS-1:0]                  max_value,
  output logic signed [SAMPLE_BITS-1:0]                  mean_value,
  output logic signed [SAMPLE_BITS-1:0]                  median_value,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]               sample_count,
  output logic                                           overflow
);
  import sss_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  state_t state, state_next;
  cell_ctl_t ctl;

  logic [CNT_W-1:0]              count, count_next;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SUM_W-1:0]       run_sum, sum_next;
  logic                          dropped;

  logic                          accept;
  logic                          room;
  logic                          keep;
  logic                          finish_now;

  // Median pick-off during the drain.
  logic [CNT_W-1:0]              step;
  logic [CNT_W-1:0]              mid;
  logic signed [SAMPLE_BITS-1:0] mid_lo;
  logic signed [SAMPLE_BITS-1:0] mid_hi;
  logic                          med_done;
  logic signed [SAMPLE_BITS:0]   mid_sum;
  logic signed [SAMPLE_BITS-1:0] median_calc;

  logic                          div_done;
  logic signed [SUM_W-1:0]       div_quo;

  logic signed [SAMPLE_BITS-1:0] cell_data [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0]        cell_gt;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);
  assign room   = (count < CNT_W'(MAX_SAMPLES));
  assign keep   = accept && room;

  assign count_next = count + CNT_W'(keep);
  assign sum_next   = keep ? run_sum + SUM_W'(sample) : run_sum;

  assign mid         = count >> 1;
  assign mid_sum     = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
  assign median_calc = count[0] ? mid_hi : mid_sum[SAMPLE_BITS:1];

  // Control: load the chain on a kept sample, drain it once the set closes.
  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.shift  = 1'b0;
    finish_now = 1'b0;
    case (state)
      ST_IDLE: begin
        ctl.load = keep;
        if (accept && last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        ctl.shift = 1'b1;
        if (med_done && div_done) begin
          finish_now = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sorting chain: each cell sees its left neighbor for insertion and its
  // right neighbor for the drain.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left_data;
    logic                          left_gt;
    logic signed [SAMPLE_BITS-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = SAMPLE_BOT;
      assign left_gt   = 1'b0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_gt   = cell_gt[i-1];
    end

    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    sss_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CNT_W'(i) < count),
      .sample_in (sample),
      .left_data (left_data),
      .left_gt   (left_gt),
      .right_data(right_data),
      .data      (cell_data[i]),
      .gt        (cell_gt[i])
    );
  end

  // Mean: start the divider on the closing transfer with the updated sum.
  sss_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && last),
    .dividend(sum_next),
    .divisor (count_next),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Set state: update on each transfer, clear once the result goes out.
  always_ff @(posedge clk) begin
    if (rst || finish_now) begin
      count   <= '0;
      run_min <= SAMPLE_TOP;
      run_max <= SAMPLE_BOT;
      run_sum <= '0;
      dropped <= 1'b0;
    end else begin
      count   <= count_next;
      run_sum <= sum_next;
      if (keep && (sample < run_min)) begin
        run_min <= sample;
      end
      if (keep && (sample > run_max)) begin
        run_max <= sample;
      end
      if (accept && !room) begin
        dropped <= 1'b1;
      end
    end
  end

  // Drain: cell zero holds sorted entry number step; grab the middle ones.
  always_ff @(posedge clk) begin
    if (rst || state == ST_IDLE) begin
      step     <= '0;
      med_done <= 1'b0;
    end else if (!med_done) begin
      step <= step + 1'b1;
      if (step == mid) begin
        med_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && !med_done) begin
      if (step == mid - 1'b1) begin
        mid_lo <= cell_data[0];
      end
      if (step == mid) begin
        mid_hi <= cell_data[0];
      end
    end
  end

  // Result register: shown for one cycle, marked by done.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish_now;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_now) begin
      min_value    <= run_min;
      max_value    <= run_max;
      mean_value   <= div_quo[SAMPLE_BITS-1:0];
      median_value <= median_calc;
      sample_count <= count;
      overflow     <= dropped;
    end
  end

endmodule

FILE: design/sss_checker.sv
// Port-level checks for sample_set_statistics, attached by bind.
// No package use; sees the top level's ports only.
module sss_checker #(
  parameter int MAX_SAMPLES = 64,
  parameter int SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              last,
  input logic                              busy,
  input logic                              done,
  input logic signed [SAMPLE_BITS-1:0]     min_value,
  input logic signed [SAMPLE_BITS-1:0]     max_value,
  input logic signed [SAMPLE_BITS-1:0]     median_value,
  input logic [$clog2(MAX_SAMPLES+1)-1:0]  sample_count
);

  // A closing transfer always leads to a busy period.
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last |=> busy)
    else $error("no busy period after the closing transfer");

  // A plain transfer never stalls the input.
  a_stream: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !last |=> !busy)
    else $error("busy raised by a transfer that does not close the set");

  // Results come one at a time, only once the block is free again.
  a_single: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy ##1 !done)
    else $error("result strobe overlaps busy or repeats");

  // A result covers at least one sample.
  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> sample_count != '0)
    else $error("result with an empty set");

  // The median lies between the extremes.
  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (min_value <= median_value) && (median_value <= max_value))
    else $error("median outside min/max range");

endmodule

bind sample_set_statistics sss_checker #(
  .MAX_SAMPLES(MAX_SAMPLES),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_sss_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .last        (last),
  .busy        (busy),
  .done        (done),
  .min_value   (min_value),
  .max_value   (max_value),
  .median_value(median_value),
  .sample_count(sample_count)
);

FILE: tb/sv/sss_stats_checker.sv
`timescale 1ns / 1ps
// Scoreboard for sample_set_statistics: watches sample and result transfers,
// predicts each set summary and compares it field by field. No dependencies.
module sss_stats_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] sample,
  input  logic               last,
  input  logic               done,
  input  logic signed [15:0] min_value,
  input  logic signed [15:0] max_value,
  input  logic signed [15:0] mean_value,
  input  logic signed [15:0] median_value,
  input  logic [6:0]         sample_count,
  input  logic               overflow,
  output int                 fail_count,
  output int                 stats_waiting,
  output int                 sets_checked
);

  localparam int Capacity = 64;

  typedef struct packed {
    logic signed [15:0] min_v;
    logic signed [15:0] max_v;
    logic signed [15:0] mean_v;
    logic signed [15:0] median_v;
    logic [6:0]         count;
    logic               ovf;
  } set_stats_t;

  set_stats_t         stats_due [$];
  logic signed [15:0] ordered [$];
  logic signed [15:0] low_mark;
  logic signed [15:0] high_mark;
  int                 total;
  logic               dropped;
  int                 misses;
  int                 results_seen;

  always @(posedge clk) begin : watch
    set_stats_t got;
    set_stats_t want;
    int         pos;
    int         n;
    int         pair;
    if (rst) begin
      stats_due.delete();
      ordered.delete();
      low_mark     = 16'sh7FFF;
      high_mark    = 16'sh8000;
      total        = 0;
      dropped      = 1'b0;
      misses       = 0;
      results_seen = 0;
    end else begin
      // Compare a result transfer against the oldest pending summary.
      if (done) begin
        got = '{min_value, max_value, mean_value, median_value, sample_count, overflow};
        if (stats_due.size() == 0) begin
          $error("result transfer with no set pending");
          misses++;
        end else begin
          want = stats_due.pop_front();
          results_seen++;
          if (got.min_v !== want.min_v) begin
            $error("min_value: expected %0d, got %0d", $signed(want.min_v), $signed(got.min_v));
            misses++;
          end
          if (got.max_v !== want.max_v) begin
            $error("max_value: expected %0d, got %0d", $signed(want.max_v), $signed(got.max_v));
            misses++;
          end
          if (got.mean_v !== want.mean_v) begin
            $error("mean_value: expected %0d, got %0d", $signed(want.mean_v),
                   $signed(got.mean_v));
            misses++;
          end
          if (got.median_v !== want.median_v) begin
            $error("median_value: expected %0d, got %0d", $signed(want.median_v),
                   $signed(got.median_v));
            misses++;
          end
          if (got.count !== want.count) begin
            $error("sample_count: expected %0d, got %0d", want.count, got.count);
            misses++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow: expected %0d, got %0d", want.ovf, got.ovf);
            misses++;
          end
        end
      end

      // Fold an accepted sample into the set; drop it once the store is full.
      if (start && !busy) begin
        if (ordered.size() < Capacity) begin
          pos = ordered.size();
          while (pos > 0 && ordered[pos-1] > sample) pos--;
          ordered.insert(pos, sample);
          if (sample < low_mark) low_mark = sample;
          if (sample > high_mark) high_mark = sample;
          total += int'(sample);
        end else begin
          dropped = 1'b1;
        end
        if (last) begin
          n             = ordered.size();
          want.min_v    = low_mark;
          want.max_v    = high_mark;
          want.mean_v   = 16'(total / n);
          if (n % 2 == 1) begin
            want.median_v = ordered[n/2];
          end else begin
            pair          = int'(ordered[n/2-1]) + int'(ordered[n/2]);
            want.median_v = 16'(pair >>> 1);
          end
          want.count = 7'(n);
          want.ovf   = dropped;
          stats_due.push_back(want);
          ordered.delete();
          low_mark  = 16'sh7FFF;
          high_mark = 16'sh8000;
          total     = 0;
          dropped   = 1'b0;
        end
      end
    end
    fail_count    <= misses;
    stats_waiting <= stats_due.size();
    sets_checked  <= results_seen;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the sample_set_statistics testbench: clock, reset, sample stimulus,
// watchdog and verdict. Depends on sample_set_statistics and sss_stats_checker.
module testbench;

  localparam int TargetSamples = 1650;
  // Past this many samples, send back to back with no gaps.
  localparam int QuietTail     = 1400;
  // Limit on cycles with no transfer, well above the longest drain plus the longest gap.
  localparam int StallLimit    = 4000;
  localparam int SettleCycles  = 40;
  localparam int DirectedLen   = 20;

  logic               clk    = 1'b0;
  logic               rst    = 1'b1;
  logic               start  = 1'b0;
  logic signed [15:0] sample = '0;
  logic               last   = 1'b0;
  logic               busy;
  logic               done;
  logic signed [15:0] min_value;
  logic signed [15:0] max_value;
  logic signed [15:0] mean_value;
  logic signed [15:0] median_value;
  logic [6:0]         sample_count;
  logic               overflow;

  int fail_count;
  int stats_waiting;
  int sets_checked;
  int samples_sent  = 0;
  int sets_sent     = 0;
  int overfull_sets = 0;
  int stall_cycles  = 0;

  // Directed sets: single extremes, the two extremes together (mean
  // truncates to zero while the median floors to -1), a negative odd pair
  // sum, ties placed after equal entries, a descending run, all negatives
  // and all zeros.
  logic signed [15:0] directed_vals [DirectedLen] = '{
    16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, -16'sd3, 16'sd0,
    16'sd5, -16'sd1, 16'sd5, 16'sd5, -16'sd1,
    16'sd300, 16'sd200, 16'sd100, -16'sd100,
    -16'sd1, -16'sd2, -16'sd3, 16'sd0, 16'sd0
  };
  logic directed_last [DirectedLen] = '{
    1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1
  };

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  sample_set_statistics #(
    .MAX_SAMPLES(64),
    .SAMPLE_BITS(16)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sample      (sample),
    .last        (last),
    .busy        (busy),
    .done        (done),
    .min_value   (min_value),
    .max_value   (max_value),
    .mean_value  (mean_value),
    .median_value(median_value),
    .sample_count(sample_count),
    .overflow    (overflow)
  );

  sss_stats_checker u_stats_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample       (sample),
    .last         (last),
    .done         (done),
    .min_value    (min_value),
    .max_value    (max_value),
    .mean_value   (mean_value),
    .median_value (median_value),
    .sample_count (sample_count),
    .overflow     (overflow),
    .fail_count   (fail_count),
    .stats_waiting(stats_waiting),
    .sets_checked (sets_checked)
  );

  // Present one sample at the falling edge and hold it until a rising edge
  // finds busy low. Start stays high into the next call, so back-to-back
  // samples stream at one per cycle while busy stays low.
  task automatic transfer_sample(input logic signed [15:0] v, input logic closes);
    @(negedge clk);
    start  <= 1'b1;
    sample <= v;
    last   <= closes;
    do @(posedge clk); while (busy);
    samples_sent++;
  endtask

  // Drop start for a burst of cycles and scramble the data lines meanwhile.
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start  <= 1'b0;
      sample <= 16'($urandom);
      last   <= 1'($urandom);
    end
  endtask

  // Send one set of len samples, last flag on the final one. Each set draws
  // its values in one style: full range, a narrow cluster (many ties), a
  // mix of extremes, or small values around zero.
  task automatic send_set(input int len);
    int                 style;
    int                 k;
    logic signed [15:0] base;
    logic signed [15:0] v;
    style = $urandom_range(0, 3);
    base  = 16'($urandom);
    for (k = 0; k < len; k++) begin
      case (style)
        0: begin
          v = 16'($urandom);
        end
        1: begin
          v = 16'(base + $urandom_range(0, 7));
        end
        2: begin
          case ($urandom_range(0, 5))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = -16'sd1;
            3:       v = 16'sd0;
            4:       v = 16'sd1;
            default: v = 16'($urandom);
          endcase
        end
        default: begin
          v = 16'(int'($urandom_range(0, 511)) - 256);
        end
      endcase
      transfer_sample(v, k == len - 1);
      // Gaps land mid-set, right after a last sample, and during the drain.
      if (samples_sent < QuietTail && $urandom_range(0, 5) == 0) begin
        hold_off($urandom_range(1, 9));
      end
    end
    sets_sent++;
    if (len > 64) overfull_sets++;
  endtask

  initial begin : stimulus
    int k;
    int pick;
    int len;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < DirectedLen; k++) begin
      transfer_sample(directed_vals[k], directed_last[k]);
      if (directed_last[k]) sets_sent++;
    end

    // Exactly full set, then sets whose tail (last flag included) is dropped.
    send_set(64);
    send_set(66);
    send_set(65);

    // Mostly short sets, some long, a few full or past capacity.
    while (samples_sent < TargetSamples) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      len = $urandom_range(1, 8);
      else if (pick < 80) len = $urandom_range(9, 40);
      else if (pick < 88) len = $urandom_range(41, 63);
      else if (pick < 93) len = 64;
      else                len = $urandom_range(65, 72);
      send_set(len);
    end

    @(negedge clk);
    start <= 1'b0;
    last  <= 1'b0;

    // Drain every pending summary, then give the block time to misbehave.
    while (stats_waiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d samples in %0d sets (%0d overfilled); %0d summaries compared.",
             samples_sent, sets_sent, overfull_sets, sets_checked);
    if (fail_count == 0) begin
      $display("sample_set_statistics verification clean");
    end else begin
      $display("sample_set_statistics verification failed");
    end
    $finish;
  end

  // Count cycles with neither a sample nor a result transfer; end a hung run.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("sample_set_statistics verification failed");
      $finish;
    end
  end

endmodule
